// ===== design/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

    // character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // decoded-group queue
    localparam int QUEUE_DEPTH = 2;
    localparam int GROUP_MAX   = 3;

    // up to three decoded bytes produced by one input word
    typedef struct packed {
        logic [1:0]                 n;
        logic [GROUP_MAX-1:0][7:0]  bytes;
        logic                       last;
    } upd_group_t;

    // queue status seen by front and top level
    typedef struct packed {
        logic full;
        logic empty;
    } upd_qstat_t;

endpackage

`default_nettype wire

// ===== design/upd_front.sv =====
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire upd_qstat_t q_stat,
    output logic            push,
    output upd_group_t      group
);

    typedef enum logic [1:0] {
        P_NONE,
        P_PCT,
        P_DIGIT
    } pend_t;

    pend_t       state_reg;
    pend_t       state_next;
    logic [7:0]  digit_reg;
    logic [7:0]  digit_next;
    logic        accept;
    logic        hex;
    logic        fresh_pct;
    logic [7:0]  fresh_out;
    logic [1:0]  n;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    // digits map straight from the low nibble, letters a-f sit nine above it
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        return b[6] ? (b[3:0] + 4'd9) : b[3:0];
    endfunction

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // classify the word against what is held
    always_comb
    begin
        group      = '0;
        n          = 2'd0;
        state_next = state_reg;
        digit_next = digit_reg;
        hex        = is_hex(in_byte);
        fresh_pct  = (in_byte == CH_PERCENT);
        fresh_out  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

        unique case (state_reg)
            P_NONE:
            begin
                if (fresh_pct)
                begin
                    state_next = P_PCT;
                end
                else
                begin
                    group.bytes[0] = fresh_out;
                    n              = 2'd1;
                end
            end
            P_PCT:
            begin
                if (hex)
                begin
                    state_next = P_DIGIT;
                    digit_next = in_byte;
                end
                else
                begin
                    // broken escape: percent out, word decoded afresh
                    group.bytes[0] = CH_PERCENT;
                    if (fresh_pct)
                    begin
                        n          = 2'd1;
                        state_next = P_PCT;
                    end
                    else
                    begin
                        group.bytes[1] = fresh_out;
                        n              = 2'd2;
                        state_next     = P_NONE;
                    end
                end
            end
            P_DIGIT:
            begin
                if (hex)
                begin
                    group.bytes[0] = {hex_val(digit_reg), hex_val(in_byte)};
                    n              = 2'd1;
                    state_next     = P_NONE;
                end
                else
                begin
                    // broken escape: percent and held digit out
                    group.bytes[0] = CH_PERCENT;
                    group.bytes[1] = digit_reg;
                    if (fresh_pct)
                    begin
                        n          = 2'd2;
                        state_next = P_PCT;
                    end
                    else
                    begin
                        group.bytes[2] = fresh_out;
                        n              = 2'd3;
                        state_next     = P_NONE;
                    end
                end
            end
            default:
            begin
                state_next = P_NONE;
            end
        endcase

        // end of string: flush what is held
        if (in_last)
        begin
            if (state_next == P_PCT)
            begin
                group.bytes[n] = CH_PERCENT;
                n              = n + 2'd1;
            end
            else if (state_next == P_DIGIT)
            begin
                group.bytes[0] = CH_PERCENT;
                group.bytes[1] = digit_next;
                n              = 2'd2;
            end
            state_next = P_NONE;
            digit_next = 8'h00;
        end

        group.n    = n;
        group.last = in_last;
    end

    assign push = accept && (n != 2'd0);

    // held escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_NONE;
            digit_reg <= 8'h00;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/upd_queue.sv =====
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire upd_group_t  push_group,
    input  wire logic        pop,
    output upd_group_t       pop_group,
    output logic             pop_valid,
    output upd_qstat_t       q_stat
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_BITS = $clog2(QUEUE_DEPTH + 1);

    upd_group_t           mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [LVL_BITS-1:0]  level_reg;
    logic [LVL_BITS-1:0]  level_next;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_stat.full  = (level_reg == LVL_BITS'(QUEUE_DEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign pop_valid    = !q_stat.empty;
    assign pop_group    = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    // pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            level_reg <= level_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_group;
    end

endmodule

`default_nettype wire

// ===== design/upd_back.sv =====
`default_nettype none

module upd_back
    import upd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire upd_group_t             q_group,
    input  wire logic                   q_valid,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [COUNT_BITS-1:0]       byte_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    upd_group_t              cur_reg;
    logic                    cur_valid_reg;
    logic [1:0]              idx_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg;
    logic                    out_last_reg;
    logic [COUNT_BITS-1:0]   byte_count_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   cnt_next;
    logic                    cur_done;
    logic                    end_of_str;
    logic                    load_out;

    assign cur_done   = (idx_reg == (cur_reg.n - 2'd1));
    assign end_of_str = cur_reg.last && cur_done;
    assign load_out   = cur_valid_reg && (!out_valid_reg || out_ready);
    assign pop        = q_valid && (!cur_valid_reg || (load_out && cur_done));

    // saturating running count, cleared after the last byte of a string
    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_next = end_of_str ? '0 : cnt_inc;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign byte_count = byte_count_reg;

    // group walker, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (load_out && cur_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_group;
        if (load_out)
        begin
            out_byte_reg   <= cur_reg.bytes[idx_reg];
            out_last_reg   <= end_of_str;
            byte_count_reg <= cnt_inc;
        end
    end

endmodule

`default_nettype wire

// ===== design/url_percent_decoder.sv =====
// url_percent_decoder: streaming form-urlencoded text decoder
//
// input channel (in_valid/in_ready): one encoded character per word in
// in_byte, with in_last on the final character of a string. output channel
// (out_valid/out_ready): one decoded byte per word, out_last on the final
// byte of a string, byte_count the saturating count of bytes so far.
//
// an input word yields zero to three output words. the front holds a pending
// percent sign and hex digit; the back walks each group out one byte a cycle
// while out_ready is high. words pass the group queue, current-group register
// and output register in turn. throughput is one input word per cycle while
// groups hold one byte and out_ready is high; larger groups take longer to go
// out; the two-entry queue absorbs that until it fills, then in_ready drops.
//
// reset clears the pending escape, the queue, the counter and out_valid.
// when the receiver stalls, the output register holds its word and the queue
// keeps accepting input until both queue entries are taken.
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [COUNT_BITS-1:0]       byte_count
);

    logic        push;
    upd_group_t  push_group;
    logic        pop;
    upd_group_t  pop_group;
    logic        pop_valid;
    upd_qstat_t  q_stat;

    // escape tracking and grouping
    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_stat   (q_stat),
        .push     (push),
        .group    (push_group)
    );

    // group queue
    upd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .pop_group  (pop_group),
        .pop_valid  (pop_valid),
        .q_stat     (q_stat)
    );

    // byte serializer and counter
    upd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_group    (pop_group),
        .q_valid    (pop_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .byte_count (byte_count)
    );

    // queue never full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("group queue status inconsistent");

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full group queue");

    // every output word has been counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != '0))
        else $error("output word with zero count");

    // a new string restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=>
            (!out_valid || (byte_count == COUNT_BITS'(1))))
        else $error("count not restarted after last byte");

endmodule

`default_nettype wire

// ===== bench/tb_url_percent_decoder.sv =====
`default_nettype none

module tb_url_percent_decoder;

    import upd_pkg::*;

    localparam int CNT_W     = 16;
    localparam int HOLD_LEN  = 300;
    localparam int LOG_LIMIT = 30;

    // one encoded character with the sender gap before it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [4:0] gap;
    } enc_char_t;

    // one decoded output word
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] count;
    } dec_word_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [7:0]       in_byte   = 8'h61;
    logic             in_last   = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_byte;
    logic             out_last;
    logic [CNT_W-1:0] byte_count;

    url_percent_decoder #(.COUNT_BITS(CNT_W)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .byte_count (byte_count)
    );

    enc_char_t char_q[$];
    dec_word_t decoded_q[$];

    // decoder shadow state
    logic [1:0]       held_n     = 2'd0;
    logic [7:0]       held_digit = 8'h00;
    logic [CNT_W-1:0] out_total  = '0;
    dec_word_t        step_buf [0:2];
    int               step_n;

    // stimulus and handshake bookkeeping
    int        gap_max     = 19;
    int        rx_max_wait = 19;
    bit        hold_arm    = 1'b0;
    bit        hold_done   = 1'b0;
    int        hold_left   = 0;
    int        rx_wait     = 0;
    int        send_wait   = 0;
    bit        send_armed  = 1'b0;
    enc_char_t next_char;
    dec_word_t want;
    logic      in_took     = 1'b0;
    logic      out_took    = 1'b0;
    int        mismatch_cnt = 0;

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 4'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return 4'(c - 8'h61 + 8'd10);
        return 4'(c - 8'h41 + 8'd10);
    endfunction

    // append one decoded byte to this step, counter saturates
    task emit_byte(input logic [7:0] c);
        if (out_total != {CNT_W{1'b1}})
            out_total = out_total + 1'b1;
        step_buf[step_n].data  = c;
        step_buf[step_n].last  = 1'b0;
        step_buf[step_n].count = out_total;
        step_n++;
    endtask

    // character seen with no escape pending
    task decode_fresh(input logic [7:0] c);
        if (c == CH_PERCENT)
            held_n = 2'd1;
        else if (c == CH_PLUS)
            emit_byte(CH_SPACE);
        else
            emit_byte(c);
    endtask

    // expected words for one accepted character
    task decode_char(input logic [7:0] c, input logic fin);
        int k;
        step_n = 0;
        case (held_n)
            2'd1:
            begin
                if (is_hex(c))
                begin
                    held_digit = c;
                    held_n     = 2'd2;
                end
                else
                begin
                    emit_byte(CH_PERCENT);
                    held_n = 2'd0;
                    decode_fresh(c);
                end
            end
            2'd2:
            begin
                held_n = 2'd0;
                if (is_hex(c))
                    emit_byte({hex_val(held_digit), hex_val(c)});
                else
                begin
                    emit_byte(CH_PERCENT);
                    emit_byte(held_digit);
                    decode_fresh(c);
                end
            end
            default:
                decode_fresh(c);
        endcase
        // end of string flushes whatever is held
        if (fin)
        begin
            if (held_n == 2'd1)
                emit_byte(CH_PERCENT);
            else if (held_n == 2'd2)
            begin
                emit_byte(CH_PERCENT);
                emit_byte(held_digit);
            end
            if (step_n > 0)
                step_buf[step_n-1].last = 1'b1;
            held_n     = 2'd0;
            held_digit = 8'h00;
            out_total  = '0;
        end
        for (k = 0; k < step_n; k++)
            decoded_q.push_back(step_buf[k]);
    endtask

    task add_char(input logic [7:0] c, input logic fin);
        enc_char_t e;
        e.data = c;
        e.last = fin;
        e.gap  = 5'($urandom_range(0, gap_max));
        char_q.push_back(e);
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(8'h30 + v);
        if ($urandom_range(0, 1))
            return 8'(8'h41 + v - 10);
        return 8'(8'h61 + v - 10);
    endfunction

    // well-formed escapes, some pluses, broken escapes and raw bytes
    task automatic add_random_string(output int n_chars);
        logic [7:0] text[$];
        int         tokens;
        int         r;
        int         i;
        tokens = $urandom_range(1, 8);
        for (i = 0; i < tokens; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                text.push_back(CH_PERCENT);
                text.push_back(rand_hex_digit());
                text.push_back(rand_hex_digit());
            end
            else if (r < 45)
                text.push_back(CH_PLUS);
            else if (r < 60)
            begin
                text.push_back(CH_PERCENT);
                if ($urandom_range(0, 1))
                    text.push_back(rand_hex_digit());
            end
            else
                text.push_back(8'($urandom_range(1, 255)));
        end
        for (i = 0; i < text.size(); i++)
            add_char(text[i], i == text.size() - 1);
        n_chars = text.size();
    endtask

    task wait_drained();
        while (char_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task note_mismatch(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= LOG_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    endtask

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // input side: note accepted words and predict their output
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            decode_char(in_byte, in_last);
            in_took <= 1'b1;
        end
        else
            in_took <= 1'b0;
    end

    // sender: next character after its gap once the slot is free
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (char_q.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                next_char = char_q[0];
                if (!send_armed)
                begin
                    send_wait  = int'(next_char.gap);
                    send_armed = 1'b1;
                end
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_byte  <= next_char.data;
                    in_last  <= next_char.last;
                    in_valid <= 1'b1;
                    void'(char_q.pop_front());
                    send_armed = 1'b0;
                end
            end
        end
    end

    // output side: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_took <= 1'b1;
            if (decoded_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= LOG_LIMIT)
                    $display({"%0t: unexpected word, expected none, ",
                              "actual byte %0h last %0b count %0d"},
                             $time, out_byte, out_last, byte_count);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data)
                    note_mismatch("out_byte", 32'(want.data), 32'(out_byte));
                if (out_last !== want.last)
                    note_mismatch("out_last", 32'(want.last), 32'(out_last));
                if (byte_count !== want.count)
                    note_mismatch("byte_count", 32'(want.count), 32'(byte_count));
            end
        end
        else
            out_took <= 1'b0;
    end

    // receiver: random stall per word, plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
                rx_wait = $urandom_range(0, rx_max_wait);
            if (hold_arm && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        int batch;
        int batch_chars;
        int n;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // escapes in both cases, decoding to the byte extremes
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h34, 1'b0);
        add_char(8'h61, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h66, 1'b0);
        add_char(8'h46, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h30, 1'b0);
        add_char(8'h30, 1'b1);
        // one-character string, plus becomes space
        add_char(CH_PLUS, 1'b1);
        // byte extremes, zero byte, broken escapes, held percent at the end
        add_char(8'h01, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'hC1, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h33, 1'b0);
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h34, 1'b0);
        add_char(8'h31, 1'b0);
        add_char(CH_PERCENT, 1'b1);
        // broken after one digit with a plus on the final character
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h62, 1'b0);
        add_char(CH_PLUS, 1'b1);
        // percent and digit held at the end
        add_char(CH_PERCENT, 1'b0);
        add_char(8'h65, 1'b1);
        wait_drained();

        // random strings in batches with different idling
        for (batch = 0; batch < 4; batch++)
        begin
            case (batch)
                0:
                begin
                    gap_max     = 3;
                    rx_max_wait = 19;
                    hold_arm    = 1'b1;
                end
                1:
                begin
                    gap_max     = 19;
                    rx_max_wait = 0;
                end
                2:
                begin
                    gap_max     = 0;
                    rx_max_wait = 0;
                end
                default:
                begin
                    gap_max     = 19;
                    rx_max_wait = 19;
                end
            endcase
            batch_chars = 0;
            while (batch_chars < 16)
            begin
                add_random_string(n);
                batch_chars += n;
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("** url_percent_decoder: PASSED **");
        else
            $display("** url_percent_decoder: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 500000);
        $display("** url_percent_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
